// File: design/sfcp_pkg.sv
// Shared constants, codes and types for the framed command parser.
package sfcp_pkg;

   // Payload bytes kept from the head of each frame (4 to 8).
   localparam int HEAD_BYTES = 4;
   localparam int HEAD_IDX_W = $clog2(HEAD_BYTES);
   localparam logic [15:0] HEAD_BYTES_LEN = 16'(HEAD_BYTES);

   localparam logic [7:0] SYNC_FIRST    = 8'h64;
   localparam logic [7:0] SYNC_SECOND   = 8'h62;
   localparam logic [7:0] CMD_THROTTLE  = 8'h01;
   localparam logic [7:0] CMD_LOG_ID    = 8'h03;
   localparam logic [7:0] CMD_RESET     = 8'h07;

   localparam logic [15:0] THROTTLE_MIN_LEN = 16'd4;
   localparam logic [15:0] MAX_LEN_RESET    = 16'd120;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MAX_PAYLOAD_LEN = 1'b0;

   typedef enum logic [2:0] {
      ACT_THROTTLE  = 3'd0,
      ACT_LOG_ID    = 3'd1,
      ACT_RESET     = 3'd2,
      ACT_IGNORED   = 3'd3,
      ACT_BAD_CK    = 3'd4
   } action_type;

   typedef enum logic [8:0] {
      PH_SYNC1   = 9'b000000001,
      PH_SYNC2   = 9'b000000010,
      PH_CMD     = 9'b000000100,
      PH_CLASS   = 9'b000001000,
      PH_LEN_LO  = 9'b000010000,
      PH_LEN_HI  = 9'b000100000,
      PH_PAYLOAD = 9'b001000000,
      PH_CK_LO   = 9'b010000000,
      PH_CK_HI   = 9'b100000000
   } phase_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  command;
      logic [7:0]  frame_class;
      logic [15:0] payload_len;
      logic [31:0] throttle_bits;
      logic [7:0]  log_id;
   } result_type;

endpackage

// File: design/sync_framed_command_parser_top.sv
// Top level of the framed command parser: byte channel in, command channel out.
//
// Usage:
//   Bytes arrive on req_rx_byte with req_valid; a byte is taken at a rising
//   edge where req_valid is high and req_stall is low. Frames are 'd','b',
//   command, class, 16-bit little-endian length, payload, 16-bit little-endian
//   checksum (wrapping sum of command, class, length and payload bytes).
//   One result word appears on the rsp_ ports for each frame, at its last
//   checksum byte; every other byte produces nothing. Frames whose length
//   exceeds the max_payload_len register (address 0, reset 120) are dropped.
//   A taken byte waits in the input register and is parsed as it leaves it;
//   its result is then held in the result register on the rsp_ ports.
//   Throughput: one byte per cycle while no result is held by rsp_stall, set by
//   the parse step between the input register and the result register.
//   Reset (synchronous): parser waits for 'd', both registers empty,
//   max_payload_len back to 120.
//   When rsp_stall holds a pending result, the result word stays put, the
//   input register still takes one byte, and req_stall rises only once that
//   byte is waiting behind the stalled result.
module sync_framed_command_parser_top
   import sfcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // byte channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_action,
   output logic [7:0]            rsp_command,
   output logic [7:0]            rsp_frame_class,
   output logic [15:0]           rsp_payload_len,
   output logic [31:0]           rsp_throttle_bits,
   output logic [7:0]            rsp_log_id,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       advance;
   logic       step;
   logic       accept;
   logic       result_fire;
   result_type result;
   logic [15:0] max_len;

   sfcp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_len     (max_len)
   );

   sfcp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (in_byte_ff),
      .max_len     (max_len),
      .result_fire (result_fire),
      .result      (result)
   );

   // The pipe moves unless a result word is held by the receiver.
   assign advance   = !(out_valid_ff && rsp_stall);
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Load a result word on a frame end; otherwise drop the taken word, but hold it while stalled.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = step && result_fire;
         if (step && result_fire) begin
            out_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_action        = out_ff.action;
   assign rsp_command       = out_ff.command;
   assign rsp_frame_class   = out_ff.frame_class;
   assign rsp_payload_len   = out_ff.payload_len;
   assign rsp_throttle_bits = out_ff.throttle_bits;
   assign rsp_log_id        = out_ff.log_id;

   a_stall_only_behind_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && in_valid_ff))
      else $error("byte channel stalled without a held result");

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> (in_valid_ff && in_byte_ff == $past(in_byte_ff)))
      else $error("waiting byte lost while result was held");

endmodule

// File: design/sfcp_csr.sv
// Register port holding the payload length limit.
module sfcp_csr
   import sfcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [15:0]           max_len
);

   logic [15:0] max_len_ff;
   logic [15:0] max_len_in;
   logic        sel_max_len;

   assign sel_max_len = (csr_paddr[2] == REG_MAX_PAYLOAD_LEN);

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_max_len) begin
         max_len_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = sel_max_len ? {{(CSR_DATA_W-16){1'b0}}, max_len_ff}
                                   : '0;
   assign max_len    = max_len_ff;

endmodule

// File: design/sfcp_parser.sv
// Frame parse state, checksum accumulation and result decode for one byte a step.
module sfcp_parser
   import sfcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  logic [15:0] max_len,
   output logic       result_fire,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  class_ff, class_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] index_ff, index_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  ck_lo_ff, ck_lo_in;
   logic [7:0]  head_ff [HEAD_BYTES];
   logic [7:0]  head_in [HEAD_BYTES];
   logic [15:0] sum_add;
   logic [15:0] full_len;
   logic [15:0] index_next;
   logic [15:0] got_ck;

   assign sum_add    = sum_ff + {8'd0, rx_byte};
   assign full_len   = {rx_byte, length_ff[7:0]};
   assign index_next = index_ff + 16'd1;
   assign got_ck     = {rx_byte, ck_lo_ff};

   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      class_in  = class_ff;
      length_in = length_ff;
      index_in  = index_ff;
      sum_in    = sum_ff;
      ck_lo_in  = ck_lo_ff;
      head_in   = head_ff;
      result_fire = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_SYNC1: begin
               if (rx_byte == SYNC_FIRST) begin
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               if (rx_byte == SYNC_SECOND) begin
                  phase_in = PH_CMD;
               end else begin
                  phase_in = PH_SYNC1;
                  index_in = '0;
                  sum_in   = '0;
               end
            end
            PH_CMD: begin
               cmd_in   = rx_byte;
               sum_in   = {8'd0, rx_byte};
               phase_in = PH_CLASS;
            end
            PH_CLASS: begin
               class_in = rx_byte;
               sum_in   = sum_add;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = {8'd0, rx_byte};
               sum_in    = sum_add;
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_in = full_len;
               sum_in    = sum_add;
               // Drop an oversize frame here, before any payload.
               if (full_len > max_len) begin
                  phase_in = PH_SYNC1;
                  index_in = '0;
                  sum_in   = '0;
               end else if (full_len == 16'd0) begin
                  phase_in = PH_CK_LO;
               end else begin
                  index_in = '0;
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (index_ff < HEAD_BYTES_LEN) begin
                  head_in[index_ff[HEAD_IDX_W-1:0]] = rx_byte;
               end
               index_in = index_next;
               sum_in   = sum_add;
               if (index_next >= length_ff) begin
                  phase_in = PH_CK_LO;
               end
            end
            PH_CK_LO: begin
               ck_lo_in = rx_byte;
               phase_in = PH_CK_HI;
            end
            PH_CK_HI: begin
               result_fire = 1'b1;
               phase_in    = PH_SYNC1;
               index_in    = '0;
               sum_in      = '0;
            end
            default: begin
               phase_in = PH_SYNC1;
               index_in = '0;
               sum_in   = '0;
            end
         endcase
      end
   end

   // Result decode, meaningful when result_fire is high.
   always_comb begin
      result.action        = ACT_IGNORED;
      result.command       = cmd_ff;
      result.frame_class   = class_ff;
      result.payload_len   = length_ff;
      result.throttle_bits = '0;
      result.log_id        = '0;
      if (got_ck != sum_ff) begin
         result.action = ACT_BAD_CK;
      end else if (cmd_ff == CMD_THROTTLE) begin
         if (length_ff >= THROTTLE_MIN_LEN) begin
            result.action        = ACT_THROTTLE;
            result.throttle_bits = {head_ff[3], head_ff[2], head_ff[1], head_ff[0]};
         end
      end else if (cmd_ff == CMD_LOG_ID) begin
         if (length_ff != 16'd0) begin
            result.action = ACT_LOG_ID;
            result.log_id = head_ff[0];
         end
      end else if (cmd_ff == CMD_RESET) begin
         result.action = ACT_RESET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC1;
         cmd_ff    <= '0;
         class_ff  <= '0;
         length_ff <= '0;
         index_ff  <= '0;
         sum_ff    <= '0;
         ck_lo_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         cmd_ff    <= cmd_in;
         class_ff  <= class_in;
         length_ff <= length_in;
         index_ff  <= index_in;
         sum_ff    <= sum_in;
         ck_lo_ff  <= ck_lo_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
   end

   a_payload_index_below_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (index_ff < length_ff))
      else $error("payload index reached length while still in payload");

   a_oversize_dropped: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_LEN_HI && full_len > max_len) |=> (phase_ff == PH_SYNC1))
      else $error("oversize frame not dropped");

   a_frame_end_resync: assert property (@(posedge clock) disable iff (reset)
      result_fire |=> (phase_ff == PH_SYNC1 && sum_ff == 16'd0))
      else $error("parser did not return to sync after a frame");

endmodule

// File: dv/sfcp_frame_checker.sv
// Scoreboard for the framed command parser: tracks bytes in, predicts and checks results.
`timescale 1ns / 100ps

module sfcp_frame_checker
   import sfcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [2:0]            rsp_action,
   input  logic [7:0]            rsp_command,
   input  logic [7:0]            rsp_frame_class,
   input  logic [15:0]           rsp_payload_len,
   input  logic [31:0]           rsp_throttle_bits,
   input  logic [7:0]            rsp_log_id,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    outstanding
);

   phase_type   frame_phase;
   logic [7:0]  frame_cmd;
   logic [7:0]  frame_class;
   logic [15:0] frame_len;
   logic [15:0] payload_pos;
   logic [15:0] running_sum;
   logic [7:0]  ck_low;
   logic [7:0]  head_bytes [HEAD_BYTES];
   logic [15:0] len_limit;
   result_type  expected_cmds [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic resync();
      frame_phase = PH_SYNC1;
      payload_pos = '0;
      running_sum = '0;
   endtask

   // Advance the parser prediction by one word; queue a result at the checksum end.
   task automatic advance_parser(input logic [7:0] b);
      result_type r;
      case (frame_phase)
         PH_SYNC1: begin
            if (b == SYNC_FIRST) frame_phase = PH_SYNC2;
         end
         PH_SYNC2: begin
            if (b == SYNC_SECOND) frame_phase = PH_CMD;
            else resync();
         end
         PH_CMD: begin
            frame_cmd   = b;
            running_sum = 16'(b);
            frame_phase = PH_CLASS;
         end
         PH_CLASS: begin
            frame_class = b;
            running_sum = running_sum + 16'(b);
            frame_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            frame_len   = 16'(b);
            running_sum = running_sum + 16'(b);
            frame_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            frame_len   = {b, frame_len[7:0]};
            running_sum = running_sum + 16'(b);
            if (frame_len > len_limit) begin
               resync();
            end else if (frame_len == 16'd0) begin
               frame_phase = PH_CK_LO;
            end else begin
               payload_pos = '0;
               frame_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (payload_pos < HEAD_BYTES_LEN) head_bytes[payload_pos[HEAD_IDX_W-1:0]] = b;
            payload_pos = payload_pos + 16'd1;
            running_sum = running_sum + 16'(b);
            if (payload_pos >= frame_len) frame_phase = PH_CK_LO;
         end
         PH_CK_LO: begin
            ck_low      = b;
            frame_phase = PH_CK_HI;
         end
         PH_CK_HI: begin
            r.action        = ACT_IGNORED;
            r.command       = frame_cmd;
            r.frame_class   = frame_class;
            r.payload_len   = frame_len;
            r.throttle_bits = '0;
            r.log_id        = '0;
            if ({b, ck_low} != running_sum) begin
               r.action = ACT_BAD_CK;
            end else if (frame_cmd == CMD_THROTTLE) begin
               if (frame_len >= THROTTLE_MIN_LEN) begin
                  r.action        = ACT_THROTTLE;
                  r.throttle_bits = {head_bytes[3], head_bytes[2], head_bytes[1], head_bytes[0]};
               end
            end else if (frame_cmd == CMD_LOG_ID) begin
               if (frame_len >= 16'd1) begin
                  r.action = ACT_LOG_ID;
                  r.log_id = head_bytes[0];
               end
            end else if (frame_cmd == CMD_RESET) begin
               r.action = ACT_RESET;
            end
            expected_cmds.push_back(r);
            resync();
         end
         default: resync();
      endcase
   endtask

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         frame_cmd   = '0;
         frame_class = '0;
         frame_len   = '0;
         ck_low      = '0;
         len_limit   = MAX_LEN_RESET;
         for (int i = 0; i < HEAD_BYTES; i++) head_bytes[i] = '0;
         resync();
         expected_cmds.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == {REG_MAX_PAYLOAD_LEN, 2'b00})
            len_limit = csr_pwdata[15:0];
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               report_mismatch("unexpected result, command", 32'(rsp_command), '0);
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_action !== want.action)
                  report_mismatch("action", 32'(rsp_action), 32'(want.action));
               if (rsp_command !== want.command)
                  report_mismatch("command", 32'(rsp_command), 32'(want.command));
               if (rsp_frame_class !== want.frame_class)
                  report_mismatch("frame_class", 32'(rsp_frame_class), 32'(want.frame_class));
               if (rsp_payload_len !== want.payload_len)
                  report_mismatch("payload_len", 32'(rsp_payload_len), 32'(want.payload_len));
               if (rsp_throttle_bits !== want.throttle_bits)
                  report_mismatch("throttle_bits", rsp_throttle_bits, want.throttle_bits);
               if (rsp_log_id !== want.log_id)
                  report_mismatch("log_id", 32'(rsp_log_id), 32'(want.log_id));
            end
         end
         if (req_valid && !req_stall) advance_parser(req_rx_byte);
      end
      outstanding = expected_cmds.size();
   end

endmodule

// File: dv/tb_top.sv
// Testbench top for the framed command parser: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
   import sfcp_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [2:0]            rsp_action;
   logic [7:0]            rsp_command;
   logic [7:0]            rsp_frame_class;
   logic [15:0]           rsp_payload_len;
   logic [31:0]           rsp_throttle_bits;
   logic [7:0]            rsp_log_id;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          fail_count;
   int          outstanding;
   int          sent_words;   // words accepted on the byte channel so far
   logic [15:0] len_limit;    // mirror of max_payload_len, used to shape frames
   bit          steady;       // when set, the sender runs back to back

   sync_framed_command_parser_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_command       (rsp_command),
      .rsp_frame_class   (rsp_frame_class),
      .rsp_payload_len   (rsp_payload_len),
      .rsp_throttle_bits (rsp_throttle_bits),
      .rsp_log_id        (rsp_log_id),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   sfcp_frame_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_command       (rsp_command),
      .rsp_frame_class   (rsp_frame_class),
      .rsp_payload_len   (rsp_payload_len),
      .rsp_throttle_bits (rsp_throttle_bits),
      .rsp_log_id        (rsp_log_id),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   always #1 clock = ~clock;

   // Hard stop: far beyond the slowest legal run (about 2k words, each waiting
   // out a long sender gap and a long receiver stall).
   initial begin
      #2000000;
      $display("tb_top: FAIL");
      $finish;
   end

   // Receiver: hold stall for random runs, mostly short, now and then long,
   // with stall-free stretches mixed in.
   initial begin
      int r;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         r = $urandom_range(0, 99);
         if (r < 12) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(40, 200)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b1;
            if (r < 85) repeat ($urandom_range(1, 3)) @(negedge clock);
            else repeat ($urandom_range(6, 25)) @(negedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   // Sender gap in cycles: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one word; return at the falling edge after it was taken, valid still high.
   task automatic push_word(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      sent_words++;
      @(negedge clock);
   endtask

   // Drop valid and hold off until every pending result is out, then let the
   // pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write max_payload_len through the register port (setup, then access).
   task automatic write_max_len(input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {REG_MAX_PAYLOAD_LEN, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      len_limit = value;
   endtask

   // Build a frame and send at most cut words of it. fill < 0 gives a random
   // payload, else every payload word is fill. A bad frame gets its checksum
   // flipped in at least one bit.
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] cls,
                             input logic [15:0] len, input bit good,
                             input int fill, input int cut);
      logic [7:0]  words [$];
      logic [15:0] sum;
      logic [7:0]  pb;
      words = {SYNC_FIRST, SYNC_SECOND, cmd, cls, len[7:0], len[15:8]};
      sum = 16'(cmd) + 16'(cls) + 16'(len[7:0]) + 16'(len[15:8]);
      // skip the payload build when only the header goes out
      if (cut > 6) begin
         for (int i = 0; i < int'(len); i++) begin
            pb = (fill < 0) ? 8'($urandom) : fill[7:0];
            words.push_back(pb);
            sum = sum + 16'(pb);
         end
      end
      if (!good) sum = sum ^ 16'($urandom_range(1, 65535));
      words.push_back(sum[7:0]);
      words.push_back(sum[15:8]);
      for (int i = 0; i < words.size() && i < cut; i++) push_word(words[i]);
   endtask

   // Payload length within the current limit, mostly short.
   function automatic logic [15:0] pick_len();
      int r;
      int top;
      r = $urandom_range(0, 99);
      if (r < 60) top = 6;
      else if (r < 92) top = 40;
      else top = 300;
      if (top > int'(len_limit)) top = int'(len_limit);
      return 16'($urandom_range(0, top));
   endfunction

   // Random traffic: mostly well-formed frames, then noise, broken syncs and
   // frames cut short.
   task automatic run_traffic(input int words);
      int          stop_at;
      int          r;
      int          cut;
      logic [7:0]  cmd;
      logic [15:0] len;
      stop_at = sent_words + words;
      while (sent_words < stop_at) begin
         if ($urandom_range(0, 19) == 0) steady = !steady;
         r = $urandom_range(0, 99);
         if (r < 75 || r >= 95) begin
            case ($urandom_range(0, 9))
               0, 1, 2: cmd = CMD_THROTTLE;
               3, 4:    cmd = CMD_LOG_ID;
               5, 6:    cmd = CMD_RESET;
               default: cmd = 8'($urandom);
            endcase
            cut = (r >= 95) ? $urandom_range(1, 8) : 1 << 30;
            if (len_limit != 16'hFFFF && $urandom_range(0, 9) == 0) begin
               // over the limit: the frame dies at its length, send the header only
               len = 16'($urandom_range(int'(len_limit) + 1, 65535));
               cut = 6;
            end else begin
               len = pick_len();
            end
            send_frame(cmd, 8'($urandom), len, $urandom_range(0, 9) != 0, -1, cut);
         end else if (r < 85) begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 3))
                  0:       push_word(SYNC_FIRST);
                  1:       push_word(SYNC_SECOND);
                  default: push_word(8'($urandom));
               endcase
            end
         end else begin
            // broken sync: 'd' then anything but 'b', sometimes a second 'd'
            push_word(SYNC_FIRST);
            if ($urandom_range(0, 2) == 0) begin
               push_word(SYNC_FIRST);
            end else begin
               cmd = 8'($urandom);
               if (cmd == SYNC_SECOND) cmd = ~cmd;
               push_word(cmd);
            end
         end
      end
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      sent_words  = 0;
      len_limit   = MAX_LEN_RESET;
      steady      = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset limit of 120.
      send_frame(CMD_THROTTLE, 8'hFF, 16'd4, 1'b1, 8'hFF, 1 << 30);  // all-ones throttle
      send_frame(CMD_THROTTLE, 8'h00, 16'd4, 1'b1, 8'h00, 1 << 30);  // all-zero throttle
      send_frame(CMD_THROTTLE, 8'h5A, 16'd3, 1'b1, -1, 1 << 30);     // too short: ignored
      send_frame(CMD_LOG_ID, 8'hA5, 16'd1, 1'b1, -1, 1 << 30);
      send_frame(CMD_LOG_ID, 8'h11, 16'd0, 1'b1, -1, 1 << 30);       // no payload: ignored
      send_frame(CMD_RESET, 8'h22, 16'd0, 1'b1, -1, 1 << 30);        // zero length to checksum
      send_frame(8'hFF, 8'h33, 16'd2, 1'b1, -1, 1 << 30);            // unknown command
      send_frame(8'h00, 8'h44, 16'd0, 1'b1, -1, 1 << 30);
      send_frame(CMD_THROTTLE, 8'h55, 16'd6, 1'b0, -1, 1 << 30);     // bad checksum
      // 'd','d','b': the second 'd' is no fresh first sync
      push_word(SYNC_FIRST);
      push_word(SYNC_FIRST);
      push_word(SYNC_SECOND);
      send_frame(CMD_RESET, 8'h66, 16'd1, 1'b1, -1, 1 << 30);
      send_frame(CMD_THROTTLE, 8'h77, 16'hFFFF, 1'b1, -1, 6);        // over limit: dropped
      send_frame(CMD_THROTTLE, 8'h88, 16'd121, 1'b1, -1, 6);         // one above the limit
      send_frame(CMD_THROTTLE, 8'h99, 16'd120, 1'b1, -1, 1 << 30);   // at the limit, long tail
      wait_idle();

      // Random phases over several limits, extremes included; drain before
      // each write so the parser sees no word around the register change.
      write_max_len(16'd0);
      run_traffic(150);
      wait_idle();
      write_max_len(16'hFFFF);
      run_traffic(350);
      wait_idle();
      write_max_len(16'($urandom_range(1, 12)));
      run_traffic(200);
      wait_idle();
      write_max_len(16'($urandom_range(13, 300)));
      run_traffic(350);
      wait_idle();
      write_max_len(MAX_LEN_RESET);
      run_traffic(400);

      // Drain, then give stray results a chance to show up.
      wait_idle();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
